/* hdl/ptes_pkg.sv */
// shared types and constants of the priority timed event scheduler
package ptes_pkg;

	localparam int NUM_QUEUES       = 5;
	localparam int NUM_SLOW_QUEUES  = 3;
	localparam int SLOW_QUEUE_DEPTH = 16;
	localparam int FAST_QUEUE_DEPTH = 8;
	localparam int HANDLER_BITS     = 8;
	localparam int TIME_BITS        = 32;
	localparam int CMDQ_DEPTH       = 2;
	localparam int CMDQ_AW          = 1;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_RUN    = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  prio;
		logic [7:0]  handler;
		logic [15:0] event_code;
		logic [31:0] delay;
		logic        cyclic;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        dispatched;
		logic [7:0]  out_handler;
		logic [15:0] out_event;
		logic [2:0]  out_prio;
		logic [31:0] earliest_due;
	} out_item_t;

	typedef enum logic [1:0] {
		K_ADD,
		K_REMOVE,
		K_RUN,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t    kind;
		in_item_t item;
	} cmd_t;

	typedef enum logic [1:0] {
		LANE_NONE,
		LANE_INSERT,
		LANE_POP,
		LANE_REMOVE
	} lane_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REINS
	} state_t;

endpackage

/* hdl/ptes_front.sv */
// front end: accepts and classifies beats into a short command queue
module ptes_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ptes_pkg::in_item_t item,
	input  logic               pop,
	output logic               cmd_vld,
	output ptes_pkg::cmd_t     cmd
);

	ptes_pkg::cmd_t                ent_q [ptes_pkg::CMDQ_DEPTH];
	logic [ptes_pkg::CMDQ_AW-1:0]  wp_q, rp_q;
	logic [ptes_pkg::CMDQ_AW:0]    cnt_q;
	ptes_pkg::kind_t               kind;
	logic                          push;
	logic                          take;

	always_comb begin
		unique case (item.action)
			ptes_pkg::ACT_ADD:    kind = ptes_pkg::K_ADD;
			ptes_pkg::ACT_REMOVE: kind = ptes_pkg::K_REMOVE;
			ptes_pkg::ACT_RUN:    kind = ptes_pkg::K_RUN;
			default:              kind = ptes_pkg::K_NOP;
		endcase
	end

	assign busy    = (cnt_q == (ptes_pkg::CMDQ_AW+1)'(ptes_pkg::CMDQ_DEPTH));
	assign push    = start && !busy;
	assign cmd_vld = (cnt_q != '0);
	assign take    = pop && cmd_vld;
	assign cmd     = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{kind: kind, item: item};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (take) rp_q <= rp_q + 1'b1;
			if (push && !take) cnt_q <= cnt_q + 1'b1;
			else if (take && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/ptes_lane.sv */
// one priority queue: a row of cells kept sorted by due time
module ptes_lane #(
	parameter int DEPTH = ptes_pkg::SLOW_QUEUE_DEPTH,
	parameter int TB    = ptes_pkg::TIME_BITS,
	parameter int HB    = ptes_pkg::HANDLER_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptes_pkg::lane_op_t op,
	input  logic [TB-1:0]      ins_due,
	input  logic [TB-1:0]      ins_ivl,
	input  logic [HB-1:0]      ins_hnd,
	input  logic [15:0]        ins_evt,
	input  logic [HB-1:0]      key_hnd,
	input  logic [15:0]        key_evt,
	output logic [TB-1:0]      head_due,
	output logic [TB-1:0]      head_ivl,
	output logic [HB-1:0]      head_hnd,
	output logic [15:0]        head_evt,
	output logic               empty,
	output logic               full,
	output logic               has_match
);

	localparam int FW = $clog2(DEPTH + 1);

	logic [TB-1:0] due_q [DEPTH];
	logic [TB-1:0] ivl_q [DEPTH];
	logic [HB-1:0] hnd_q [DEPTH];
	logic [15:0]   evt_q [DEPTH];
	logic [FW-1:0] fill_q;
	logic [DEPTH-1:0] vld, le, mt, pre;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = (FW'(i) < fill_q);
			le[i]  = vld[i] && (due_q[i] <= ins_due);
			mt[i]  = vld[i] && (hnd_q[i] == key_hnd) && (evt_q[i] == key_evt);
		end
		pre[0] = 1'b0;
		for (int i = 1; i < DEPTH; i++) begin
			pre[i] = pre[i-1] | mt[i-1];
		end
	end

	assign empty     = (fill_q == '0);
	assign full      = (fill_q == FW'(DEPTH));
	assign has_match = |mt;
	assign head_due  = due_q[0];
	assign head_ivl  = ivl_q[0];
	assign head_hnd  = hnd_q[0];
	assign head_evt  = evt_q[0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			unique case (op)
				ptes_pkg::LANE_INSERT: begin
					if (!le[i]) begin
						if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
							due_q[i] <= ins_due;
							ivl_q[i] <= ins_ivl;
							hnd_q[i] <= ins_hnd;
							evt_q[i] <= ins_evt;
						end else begin
							due_q[i] <= due_q[(i == 0) ? 0 : i-1];
							ivl_q[i] <= ivl_q[(i == 0) ? 0 : i-1];
							hnd_q[i] <= hnd_q[(i == 0) ? 0 : i-1];
							evt_q[i] <= evt_q[(i == 0) ? 0 : i-1];
						end
					end
				end
				ptes_pkg::LANE_POP, ptes_pkg::LANE_REMOVE: begin
					if (i < DEPTH-1 && (op == ptes_pkg::LANE_POP || mt[i] || pre[i])) begin
						due_q[i] <= due_q[(i < DEPTH-1) ? i+1 : i];
						ivl_q[i] <= ivl_q[(i < DEPTH-1) ? i+1 : i];
						hnd_q[i] <= hnd_q[(i < DEPTH-1) ? i+1 : i];
						evt_q[i] <= evt_q[(i < DEPTH-1) ? i+1 : i];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			unique case (op)
				ptes_pkg::LANE_INSERT: if (!full) fill_q <= fill_q + 1'b1;
				ptes_pkg::LANE_POP:    if (!empty) fill_q <= fill_q - 1'b1;
				ptes_pkg::LANE_REMOVE: if (has_match) fill_q <= fill_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH)) else $error("lane fill beyond depth");

endmodule

/* hdl/ptes_back.sv */
// back end: sequencer that carries out add, remove and run on the lanes
module ptes_back #(
	parameter int SLOW_QUEUE_DEPTH = ptes_pkg::SLOW_QUEUE_DEPTH,
	parameter int FAST_QUEUE_DEPTH = ptes_pkg::FAST_QUEUE_DEPTH,
	parameter int HANDLER_BITS     = ptes_pkg::HANDLER_BITS,
	parameter int TIME_BITS        = ptes_pkg::TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_vld,
	input  ptes_pkg::cmd_t      cmd,
	output logic                pop,
	output logic                done,
	output ptes_pkg::out_item_t result
);

	localparam int NQ = ptes_pkg::NUM_QUEUES;
	localparam int TB = TIME_BITS;
	localparam int HB = HANDLER_BITS;

	ptes_pkg::state_t    st_q, st_d;
	ptes_pkg::cmd_t      cur_q;
	logic [TB-1:0]       nct_q, nct_d;
	logic [TB-1:0]       hd_due_q, hd_ivl_q;
	logic [HB-1:0]       hd_hnd_q;
	logic [15:0]         hd_evt_q;
	logic [2:0]          hd_q_q;
	logic                latch_hd;
	ptes_pkg::out_item_t res_d, res_q;
	logic                done_d, done_q;

	ptes_pkg::lane_op_t  lop [NQ];
	logic [TB-1:0]       ins_due, ins_ivl;
	logic [HB-1:0]       ins_hnd;
	logic [15:0]         ins_evt;
	logic [TB-1:0]       h_due [NQ];
	logic [TB-1:0]       h_ivl [NQ];
	logic [HB-1:0]       h_hnd [NQ];
	logic [15:0]         h_evt [NQ];
	logic [NQ-1:0]       emp, ful, mat, due_ok;

	logic [TB-1:0]       now_w, due_w, least;
	logic [HB-1:0]       hnd_w;
	logic                found, prio_ok;
	logic [2:0]          sel;

	for (genvar q = 0; q < NQ; q++) begin : g_lane
		ptes_lane #(
			.DEPTH((q < ptes_pkg::NUM_SLOW_QUEUES) ? SLOW_QUEUE_DEPTH : FAST_QUEUE_DEPTH),
			.TB(TB),
			.HB(HB)
		) u_lane (
			.clk(clk), .arst_n(arst_n), .op(lop[q]),
			.ins_due(ins_due), .ins_ivl(ins_ivl), .ins_hnd(ins_hnd), .ins_evt(ins_evt),
			.key_hnd(hnd_w), .key_evt(cur_q.item.event_code),
			.head_due(h_due[q]), .head_ivl(h_ivl[q]), .head_hnd(h_hnd[q]),
			.head_evt(h_evt[q]), .empty(emp[q]), .full(ful[q]), .has_match(mat[q])
		);
	end

	assign now_w   = TB'(cur_q.item.now);
	assign due_w   = now_w + TB'(cur_q.item.delay);
	assign hnd_w   = HB'(cur_q.item.handler);
	assign prio_ok = (cur_q.item.prio < 3'(NQ));

	always_comb begin
		found = 1'b0;
		sel   = '0;
		least = '1;
		for (int q = 0; q < NQ; q++) begin
			due_ok[q] = !emp[q] && (h_due[q] <= now_w);
			if (due_ok[q]) begin
				found = 1'b1;
				sel   = 3'(q);
			end
			if (!emp[q] && h_due[q] < least) least = h_due[q];
		end
	end

	assign pop = (st_q == ptes_pkg::S_IDLE);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ptes_pkg::S_IDLE: if (cmd_vld) st_d = ptes_pkg::S_EXEC;
			ptes_pkg::S_EXEC: begin
				unique case (cur_q.kind)
					ptes_pkg::K_REMOVE: if (!(|mat)) st_d = ptes_pkg::S_IDLE;
					ptes_pkg::K_RUN: begin
						if (nct_q <= now_w && found && h_ivl[sel] != '0)
							st_d = ptes_pkg::S_REINS;
						else
							st_d = ptes_pkg::S_IDLE;
					end
					default: st_d = ptes_pkg::S_IDLE;
				endcase
			end
			ptes_pkg::S_REINS: st_d = ptes_pkg::S_IDLE;
			default: st_d = ptes_pkg::S_IDLE;
		endcase
	end

	// outputs and lane controls
	always_comb begin
		for (int q = 0; q < NQ; q++) lop[q] = ptes_pkg::LANE_NONE;
		ins_due  = due_w;
		ins_ivl  = cur_q.item.cyclic ? TB'(cur_q.item.delay) : '0;
		ins_hnd  = hnd_w;
		ins_evt  = cur_q.item.event_code;
		nct_d    = nct_q;
		latch_hd = 1'b0;
		done_d   = 1'b0;
		res_d    = '0;
		res_d.status = ptes_pkg::STATUS_OK;
		unique case (st_q)
			ptes_pkg::S_EXEC: begin
				unique case (cur_q.kind)
					ptes_pkg::K_ADD: begin
						if (due_w < nct_q) nct_d = due_w;
						done_d = 1'b1;
						if (!prio_ok) res_d.status = ptes_pkg::STATUS_INVALID;
						else if (ful[cur_q.item.prio]) res_d.status = ptes_pkg::STATUS_FULL;
						else lop[cur_q.item.prio] = ptes_pkg::LANE_INSERT;
					end
					ptes_pkg::K_REMOVE: begin
						if (|mat) begin
							for (int q = 0; q < NQ; q++) lop[q] = ptes_pkg::LANE_REMOVE;
						end else begin
							done_d = 1'b1;
						end
					end
					ptes_pkg::K_RUN: begin
						if (nct_q <= now_w && found) begin
							lop[sel] = ptes_pkg::LANE_POP;
							latch_hd = 1'b1;
							done_d   = (h_ivl[sel] == '0);
							res_d.dispatched  = 1'b1;
							res_d.out_handler = 8'(h_hnd[sel]);
							res_d.out_event   = h_evt[sel];
							res_d.out_prio    = sel;
						end else begin
							if (nct_q <= now_w) nct_d = least;
							done_d = 1'b1;
						end
					end
					default: done_d = 1'b1;
				endcase
			end
			ptes_pkg::S_REINS: begin
				lop[hd_q_q] = ptes_pkg::LANE_INSERT;
				ins_due = hd_due_q + hd_ivl_q;
				ins_ivl = hd_ivl_q;
				ins_hnd = hd_hnd_q;
				ins_evt = hd_evt_q;
				done_d  = 1'b1;
				res_d.dispatched  = 1'b1;
				res_d.out_handler = 8'(hd_hnd_q);
				res_d.out_event   = hd_evt_q;
				res_d.out_prio    = hd_q_q;
			end
			default: begin
			end
		endcase
		res_d.earliest_due = 32'(nct_d);
	end

	always_ff @(posedge clk) begin
		if (pop && cmd_vld) cur_q <= cmd;
		if (latch_hd) begin
			hd_due_q <= h_due[sel];
			hd_ivl_q <= h_ivl[sel];
			hd_hnd_q <= h_hnd[sel];
			hd_evt_q <= h_evt[sel];
			hd_q_q   <= sel;
		end
		if (done_d) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ptes_pkg::S_IDLE;
			nct_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			nct_q  <= nct_d;
			done_q <= done_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_reins_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ptes_pkg::S_REINS |-> $past(st_q) == ptes_pkg::S_EXEC
		&& cur_q.kind == ptes_pkg::K_RUN) else $error("reinsert without run");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q) == ptes_pkg::S_EXEC || $past(st_q) == ptes_pkg::S_REINS)
		else $error("result beat without work");

	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.dispatched |-> res_q.status == ptes_pkg::STATUS_OK)
		else $error("dispatch with error status");

endmodule

/* hdl/priority_timed_event_scheduler_unit.sv */
// top level of the priority timed event scheduler
// Each accepted beat gives exactly one result beat on done, which the receiver
// cannot stall. The sequencer in the back end works the queues one operation a
// cycle: an add is done in its execute state, a run pops the due head, if one
// is due, and puts a cyclic event back in a reinsert state, and a remove takes
// the first matching entry out of each queue that holds one, step by step until
// none is left. It takes a new command only while idle. A two-entry command
// queue sits in front; busy is high while it is full.
module priority_timed_event_scheduler_unit #(
	parameter int SLOW_QUEUE_DEPTH = ptes_pkg::SLOW_QUEUE_DEPTH,
	parameter int FAST_QUEUE_DEPTH = ptes_pkg::FAST_QUEUE_DEPTH,
	parameter int HANDLER_BITS     = ptes_pkg::HANDLER_BITS,
	parameter int TIME_BITS        = ptes_pkg::TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ptes_pkg::in_item_t  item,
	output logic                done,
	output ptes_pkg::out_item_t result
);

	logic           pop, cmd_vld;
	ptes_pkg::cmd_t cmd;

	ptes_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.pop(pop), .cmd_vld(cmd_vld), .cmd(cmd)
	);

	ptes_back #(
		.SLOW_QUEUE_DEPTH(SLOW_QUEUE_DEPTH),
		.FAST_QUEUE_DEPTH(FAST_QUEUE_DEPTH),
		.HANDLER_BITS(HANDLER_BITS),
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_vld(cmd_vld), .cmd(cmd), .pop(pop),
		.done(done), .result(result)
	);

endmodule

/* test/tb.sv */
// testbench of the priority timed event scheduler: scoreboard checks directed and random beats
`timescale 1ns / 100ps

module tb;

	class sched_scoreboard;
		logic [31:0] due_q[5][$];
		logic [31:0] ivl_q[5][$];
		logic [7:0]  hnd_q[5][$];
		logic [15:0] evt_q[5][$];
		logic [31:0] next_chk;
		ptes_pkg::out_item_t pending[$];
		int          errors;

		function new();
			for (int q = 0; q < ptes_pkg::NUM_QUEUES; q++) begin
				due_q[q].delete(); ivl_q[q].delete();
				hnd_q[q].delete(); evt_q[q].delete();
			end
			next_chk = '0;
			errors = 0;
		endfunction

		function int depth_of(int q);
			return (q < ptes_pkg::NUM_SLOW_QUEUES) ? ptes_pkg::SLOW_QUEUE_DEPTH
				: ptes_pkg::FAST_QUEUE_DEPTH;
		endfunction

		function bit push_sorted(int q, logic [31:0] d, logic [31:0] iv, logic [7:0] h,
				logic [15:0] e);
			int pos;
			if (due_q[q].size() >= depth_of(q)) return 1'b1;
			pos = 0;
			while (pos < due_q[q].size() && due_q[q][pos] <= d) pos++;
			due_q[q].insert(pos, d); ivl_q[q].insert(pos, iv);
			hnd_q[q].insert(pos, h); evt_q[q].insert(pos, e);
			return 1'b0;
		endfunction

		function void note_beat(ptes_pkg::in_item_t it);
			ptes_pkg::out_item_t r;
			logic [31:0] d, iv, least;
			r = '0;
			if (it.action == ptes_pkg::ACT_ADD) begin
				d = it.now + it.delay;
				iv = it.cyclic ? it.delay : 32'd0;
				if (d < next_chk) next_chk = d;
				if (it.prio < ptes_pkg::NUM_QUEUES)
					r.status = push_sorted(int'(it.prio), d, iv, it.handler, it.event_code)
						? ptes_pkg::STATUS_FULL : ptes_pkg::STATUS_OK;
				else
					r.status = ptes_pkg::STATUS_INVALID;
			end else if (it.action == ptes_pkg::ACT_REMOVE) begin
				for (int q = 0; q < ptes_pkg::NUM_QUEUES; q++)
					for (int i = due_q[q].size() - 1; i >= 0; i--)
						if (hnd_q[q][i] == it.handler && evt_q[q][i] == it.event_code) begin
							due_q[q].delete(i); ivl_q[q].delete(i);
							hnd_q[q].delete(i); evt_q[q].delete(i);
						end
			end else if (it.action == ptes_pkg::ACT_RUN && next_chk <= it.now) begin
				for (int q = ptes_pkg::NUM_QUEUES - 1; q >= 0; q--)
					if (due_q[q].size() != 0 && due_q[q][0] <= it.now) begin
						r.dispatched = 1'b1;
						r.out_prio = 3'(q);
						r.out_handler = hnd_q[q][0];
						r.out_event = evt_q[q][0];
						d = due_q[q].pop_front(); iv = ivl_q[q].pop_front();
						void'(hnd_q[q].pop_front()); void'(evt_q[q].pop_front());
						if (iv != 0) void'(push_sorted(q, d + iv, iv, r.out_handler, r.out_event));
						break;
					end
				if (!r.dispatched) begin
					least = '1;
					for (int q = 0; q < ptes_pkg::NUM_QUEUES; q++)
						if (due_q[q].size() != 0 && due_q[q][0] < least) least = due_q[q][0];
					next_chk = least;
				end
			end
			r.earliest_due = next_chk;
			pending.push_back(r);
		endfunction

		function void check_beat(ptes_pkg::out_item_t got);
			ptes_pkg::out_item_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status || got.dispatched !== exp_r.dispatched ||
					got.out_handler !== exp_r.out_handler || got.out_event !== exp_r.out_event ||
					got.out_prio !== exp_r.out_prio || got.earliest_due !== exp_r.earliest_due) begin
				$display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	ptes_pkg::in_item_t  item;
	logic      done;
	ptes_pkg::out_item_t result;
	longint    cycles;
	logic [31:0] tick;
	sched_scoreboard sb;

	priority_timed_event_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_beat(result);
		if (cycles > 600000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_beat(ptes_pkg::in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_beat(it);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic ptes_pkg::in_item_t make_beat(logic [1:0] a, logic [2:0] p,
			logic [7:0] h, logic [15:0] e, logic [31:0] d, logic c, logic [31:0] n);
		ptes_pkg::in_item_t it;
		it.action = a; it.prio = p; it.handler = h; it.event_code = e;
		it.delay = d; it.cyclic = c; it.now = n;
		return it;
	endfunction

	function automatic ptes_pkg::in_item_t rand_beat();
		ptes_pkg::in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it = '0;
		it.handler = 8'($urandom_range(0, 3));
		it.event_code = 16'($urandom_range(0, 3));
		it.prio = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
		it.cyclic = 1'($urandom);
		it.delay = $urandom_range(0, 40);
		if ($urandom_range(0, 19) == 0) begin
			it.handler = 8'($urandom); it.event_code = 16'($urandom); it.delay = $urandom;
		end
		if (r < 45) it.action = ptes_pkg::ACT_ADD;
		else if (r < 52) it.action = ptes_pkg::ACT_REMOVE;
		else if (r < 98) it.action = ptes_pkg::ACT_RUN;
		else it.action = ptes_pkg::ACT_NONE;
		it.now = ($urandom_range(0, 49) == 0) ? $urandom : tick;
		return it;
	endfunction

	initial begin
		sb = new();
		cycles = 0;
		start = 1'b0;
		item = '0;
		tick = 32'd100;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd4, 8'hff, 16'hffff, 32'hffffffff, 1'b1,
			32'hffffffff));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd0, 8'h00, 16'h0000, 32'd0, 1'b1, 32'd5));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd7, 8'h12, 16'h3456, 32'd1, 1'b0, 32'd1));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd5, 8'h12, 16'h3456, 32'd1, 1'b0, 32'd1));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd2, 8'h01, 16'h0001, 32'd3, 1'b1, 32'd2));
		send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd2, 8'h02, 16'h0002, 32'd3, 1'b0, 32'd2));
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'd1));
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'd10));
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'd10));
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'd10));
		for (int i = 0; i < 9; i++)
			send_beat(make_beat(ptes_pkg::ACT_ADD, 3'd3, 8'h07, 16'h0007, 32'd50, 1'b0,
				32'd10));
		send_beat(make_beat(ptes_pkg::ACT_REMOVE, 3'd0, 8'h07, 16'h0007, 32'd0, 1'b0, 32'd10));
		send_beat(make_beat(ptes_pkg::ACT_REMOVE, 3'd0, 8'hff, 16'hffff, 32'd0, 1'b0, 32'd10));
		send_beat(make_beat(ptes_pkg::ACT_NONE, 3'd7, 8'hff, 16'hffff, 32'hffffffff, 1'b1,
			32'hffffffff));
		send_beat(make_beat(ptes_pkg::ACT_RUN, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 32'hffffffff));
		drain();
		for (int n = 0; n < 2000; n++) begin
			if ($urandom_range(0, 2) == 0) tick = tick + $urandom_range(0, 8);
			send_beat(rand_beat());
			if (n == 1000) drain();
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
